// ===== sv/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Types and constants shared by the shell line tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

	typedef enum logic [3:0] {
		TK_WORD    = 4'd0,
		TK_PIPE    = 4'd1,
		TK_INPUT   = 4'd2,
		TK_TRUNC   = 4'd3,
		TK_HEREDOC = 4'd4,
		TK_APPEND  = 4'd5,
		TK_END     = 4'd6,
		TK_OPEN_SQ = 4'd7,
		TK_OPEN_DQ = 4'd8
	} tok_kind_t;

	typedef enum logic [1:0] {
		QM_PLAIN  = 2'd0,
		QM_SINGLE = 2'd1,
		QM_DOUBLE = 2'd2
	} quote_mode_t;

	typedef enum logic [1:0] {
		PR_NONE = 2'd0,
		PR_LT   = 2'd1,
		PR_GT   = 2'd2
	} pend_redir_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int START_LIMIT = 4095;
	localparam int LEN_LIMIT   = 4096;
	localparam int MAX_TOKS    = 3;

	typedef struct packed {
		tok_kind_t            kind;
		logic [START_W-1:0]   start;
		logic [LEN_W-1:0]     length;
		logic                 last;
	} token_t;

	typedef struct packed {
		quote_mode_t qm;
		pend_redir_t pend;
		logic        prev_sep;
	} lex_state_t;

endpackage

`default_nettype wire

// ===== sv/shell_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Splits a command line, one byte per transaction, into shell tokens.
// ----------------------------------------------------------------------------
// Input channel s_*: one line byte per transaction in s_tdata; byte 0 ends the
// line and returns the lexer to its start state for the next line.
// Output channel m_*: one token per transaction; m_tuser is the token kind,
// m_tdata carries start offset and length, m_tlast marks the last token
// caused by one input byte. A byte may cause zero to two tokens.
// Path: a byte accepted on s_* passes the input register and then the result
// register before its first token shows on m_* (two register stages).
// Throughput: one byte per cycle while each byte yields at most one token
// and m_tready is high; a byte yielding two tokens holds the result register
// until the single output port takes its last token.
// Reset (arst_n low): no tokens pending, lexer at the start of a line.
// When the receiver stalls, the result register and then the input register
// fill, and s_tready drops until tokens drain.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_line_tokenizer #(
	parameter int MAX_LINE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [11:0] token_start, [24:12] token_length
	output logic [3:0]       m_tuser,   // [3:0] token_kind
	output logic             m_tlast    // last_of_run
);
	import slt_pkg::*;

	localparam int POS_W = $clog2(MAX_LINE + 2);

	logic [7:0]       char_s1;
	logic             valid_s1;
	lex_state_t       st_q, st_nxt;
	logic [POS_W-1:0] pos_q, pos_nxt;
	logic [POS_W-1:0] wbeg_q, wbeg_nxt;
	token_t           toks [MAX_TOKS];
	logic [1:0]       tok_cnt;
	logic             free;
	logic             proceed;

	assign proceed  = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '{qm: QM_PLAIN, pend: PR_NONE, prev_sep: 1'b1};
			pos_q  <= '0;
			wbeg_q <= '0;
		end else if (proceed) begin
			st_q   <= st_nxt;
			pos_q  <= pos_nxt;
			wbeg_q <= wbeg_nxt;
		end
	end

	slt_step #(
		.MAX_LINE (MAX_LINE),
		.POS_W    (POS_W)
	) u_step (
		.char_code (char_s1),
		.cur       (st_q),
		.pos       (pos_q),
		.wbeg      (wbeg_q),
		.nxt       (st_nxt),
		.npos      (pos_nxt),
		.nwbeg     (wbeg_nxt),
		.toks      (toks),
		.tok_cnt   (tok_cnt)
	);

	slt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (proceed),
		.toks     (toks),
		.tok_cnt  (tok_cnt),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/slt_step.sv =====
// ----------------------------------------------------------------------------
// slt_step
// Per-byte tokenizer logic: next state and packed tokens (at most two per byte).
// ----------------------------------------------------------------------------
`default_nettype none

module slt_step #(
	parameter int MAX_LINE = 4096,
	parameter int POS_W    = 13
) (
	input  wire logic [7:0]             char_code,
	input  wire slt_pkg::lex_state_t    cur,
	input  wire logic [POS_W-1:0]       pos,
	input  wire logic [POS_W-1:0]       wbeg,
	output slt_pkg::lex_state_t         nxt,
	output logic [POS_W-1:0]            npos,
	output logic [POS_W-1:0]            nwbeg,
	output slt_pkg::token_t             toks [slt_pkg::MAX_TOKS],
	output logic [1:0]                  tok_cnt
);
	import slt_pkg::*;

	localparam int StartCap = (MAX_LINE - 1 < START_LIMIT) ? MAX_LINE - 1 : START_LIMIT;
	localparam int LenCap   = (MAX_LINE < LEN_LIMIT) ? MAX_LINE : LEN_LIMIT;

	function automatic logic [START_W-1:0] clamp_start(input logic [POS_W-1:0] v);
		if (32'(v) > StartCap) return START_W'(StartCap);
		return START_W'(v);
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [POS_W-1:0] v);
		if (32'(v) > LenCap) return LEN_W'(LenCap);
		return LEN_W'(v);
	endfunction

	logic              is_sep;
	logic [POS_W-1:0]  first;
	logic [POS_W-1:0]  pos_adv;
	logic [POS_W-1:0]  word_len;
	logic              word_ok;
	quote_mode_t       qm_upd;
	logic [7:0]        redir_ch;
	logic              a_v, b_v, c_v;
	token_t            a_tok, b_tok, c_tok;
	logic [1:0]        cnt;

	assign is_sep = (char_code > CH_TAB - 8'd1 && char_code < CH_CR + 8'd1)
		|| char_code == CH_SPACE || char_code == CH_PIPE
		|| char_code == CH_LT || char_code == CH_GT;
	assign first    = (pos != '0) ? pos - POS_W'(1) : '0;
	assign pos_adv  = (32'(pos) < MAX_LINE) ? pos + POS_W'(1) : pos;
	assign word_len = (pos >= wbeg) ? pos - wbeg : '0;
	assign word_ok  = !cur.prev_sep && pos != '0;
	assign redir_ch = (cur.pend == PR_LT) ? CH_LT : CH_GT;

	always_comb begin
		qm_upd = cur.qm;
		unique case (cur.qm)
			QM_PLAIN: begin
				if (char_code == CH_SQ) qm_upd = QM_SINGLE;
				else if (char_code == CH_DQ) qm_upd = QM_DOUBLE;
			end
			QM_SINGLE: if (char_code == CH_SQ) qm_upd = QM_PLAIN;
			QM_DOUBLE: if (char_code == CH_DQ) qm_upd = QM_PLAIN;
			default: qm_upd = cur.qm;
		endcase
	end

	always_comb begin
		a_v = 1'b0;
		b_v = 1'b0;
		c_v = 1'b0;
		a_tok = '{kind: TK_INPUT, start: clamp_start(first), length: clamp_len(POS_W'(1)),
			last: 1'b0};
		b_tok = '{kind: TK_WORD, start: clamp_start(wbeg), length: clamp_len(word_len),
			last: 1'b0};
		c_tok = '{kind: TK_END, start: clamp_start(pos), length: '0, last: 1'b0};
		nxt   = cur;
		npos  = pos;
		nwbeg = wbeg;

		if (cur.pend != PR_NONE && char_code == redir_ch) begin
			// doubled redirect: consume this byte
			a_v          = 1'b1;
			a_tok.kind   = (cur.pend == PR_LT) ? TK_HEREDOC : TK_APPEND;
			a_tok.length = clamp_len(POS_W'(2));
			nxt.pend     = PR_NONE;
			nwbeg        = pos + POS_W'(1);
			nxt.prev_sep = is_sep;
			npos         = pos_adv;
		end else begin
			if (cur.pend != PR_NONE) begin
				a_v        = 1'b1;
				a_tok.kind = (cur.pend == PR_LT) ? TK_INPUT : TK_TRUNC;
				nxt.pend   = PR_NONE;
			end
			if (char_code == CH_NUL) begin
				c_v = 1'b1;
				if (cur.qm == QM_SINGLE) c_tok.kind = TK_OPEN_SQ;
				else if (cur.qm == QM_DOUBLE) c_tok.kind = TK_OPEN_DQ;
				else begin
					b_v = word_ok;
				end
				nxt   = '{qm: QM_PLAIN, pend: PR_NONE, prev_sep: 1'b1};
				npos  = '0;
				nwbeg = '0;
			end else begin
				nxt.qm = qm_upd;
				if (qm_upd == QM_PLAIN && is_sep) begin
					b_v = word_ok;
					if (char_code == CH_PIPE) begin
						c_v          = 1'b1;
						c_tok.kind   = TK_PIPE;
						c_tok.length = clamp_len(POS_W'(1));
					end else if (char_code == CH_LT) nxt.pend = PR_LT;
					else if (char_code == CH_GT) nxt.pend = PR_GT;
					nwbeg = pos + POS_W'(1);
				end
				nxt.prev_sep = is_sep;
				npos         = pos_adv;
			end
		end
	end

	// pack valid tokens to the front, mark the final one
	always_comb begin
		cnt = 2'(a_v) + 2'(b_v) + 2'(c_v);
		toks[0] = a_v ? a_tok : (b_v ? b_tok : c_tok);
		toks[1] = a_v ? (b_v ? b_tok : c_tok) : c_tok;
		toks[2] = c_tok;
		unique case (cnt)
			2'd1: toks[0].last = 1'b1;
			2'd2: toks[1].last = 1'b1;
			2'd3: toks[2].last = 1'b1;
			default: ;
		endcase
	end

	assign tok_cnt = cnt;

endmodule

`default_nettype wire

// ===== sv/slt_outq.sv =====
// ----------------------------------------------------------------------------
// slt_outq
// Result register: holds the tokens of one byte and drains them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire slt_pkg::token_t  toks [slt_pkg::MAX_TOKS],
	input  wire logic [1:0]       tok_cnt,
	output logic                  free,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [31:0]           m_tdata,  // [11:0] token_start, [24:12] token_length
	output logic [3:0]            m_tuser,  // [3:0] token_kind
	output logic                  m_tlast   // last_of_run
);
	import slt_pkg::*;

	token_t     q_q [MAX_TOKS];
	logic [1:0] cnt_q;
	logic       pop;

	assign pop  = cnt_q != 2'd0 && m_tready;
	assign free = cnt_q == 2'd0 || (cnt_q == 2'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= tok_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= toks;
		end else if (pop) begin
			// advance the remaining tokens toward the head
			q_q[0] <= q_q[1];
			q_q[1] <= q_q[2];
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {7'd0, q_q[0].length, q_q[0].start};
	assign m_tuser  = q_q[0].kind;
	assign m_tlast  = q_q[0].last;

endmodule

`default_nettype wire
